// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define ASSERT_IMPL(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(name, prop)
`define ASSERT_NEVER(name, prop)
`endif
`endif

// ===== src/psal_pkg.sv =====
// ---------------------------------------------------------------------------
// Polyline splitter package
// Register indexes and the sequencer state encoding.
// ---------------------------------------------------------------------------
package psal_pkg;

  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_AXIS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUT_COORD = 2'd1;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EMIT_H  = 6'b000010,
    S_CALC    = 6'b000100,
    S_EMIT_I1 = 6'b001000,
    S_EMIT_I0 = 6'b010000,
    S_EMIT_V  = 6'b100000
  } state_e;

endpackage

// ===== src/psal_muldiv.sv =====
// ---------------------------------------------------------------------------
// Serial multiply-divide unit
// Computes (a * b) / d on unsigned magnitudes, one bit per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psal_muldiv #(
  parameter int unsigned W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W:0]   a_i,
  input  logic [W:0]   b_i,
  input  logic [W:0]   d_i,
  output logic         done_o,
  output logic [W:0]   quot_o
);

  localparam int unsigned CW = $clog2(W + 2);

  logic [CW-1:0] cnt_q;
  logic          busy_q, div_q, done_q;
  logic [W:0]    a_q, d_q, hi_q, lo_q;

  logic [W+1:0]  sum;
  logic [W+1:0]  rem2;
  logic [W+1:0]  diff;
  logic          ge;
  logic          last_step;

  // The multiply phase adds the multiplicand into the high half and shifts the
  // product right. The divide phase reuses both halves as a restoring divider.
  assign sum       = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  assign rem2      = {hi_q, lo_q[W]};
  assign diff      = rem2 - {1'b0, d_q};
  assign ge        = (rem2 >= {1'b0, d_q});
  assign last_step = (cnt_q == CW'(W));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (last_step) begin
        cnt_q <= '0;
        if (div_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          div_q <= 1'b1;
        end
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      d_q  <= d_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q && !div_q) begin
      hi_q <= sum[W+1:1];
      lo_q <= {sum[0], lo_q[W:1]};
    end else if (busy_q) begin
      hi_q <= ge ? diff[W:0] : rem2[W:0];
      lo_q <= {lo_q[W-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

  `ASSERT_IMPL(a_rem_below_divisor, busy_q && div_q |-> hi_q < d_q)
  `ASSERT_NEVER(a_start_while_busy, start_i && busy_q)
  `ASSERT_IMPL(a_done_after_busy, $rose(done_q) |-> $past(busy_q))

endmodule

// ===== src/polyline_split_at_axis_line.sv =====
// ---------------------------------------------------------------------------
// Polyline splitter at an axis-aligned line
// Cuts a stream of polyline vertices at x = cut or y = cut and streams out
// the vertices of the resulting pieces.
// ---------------------------------------------------------------------------
// Usage: vertices enter on the input channel (in_valid_i / in_stall_o); each
// transaction carries one vertex and a path_last flag. Output transactions
// (out_valid_o / out_stall_i) carry piece vertices with piece_end and
// path_end flags. Each vertex is emitted when the segment leaving it is
// known, so one input transaction gives zero to four output transactions.
// A crossing of the cut line adds the intersection point twice, the first
// copy closing the current piece; when the start vertex lies on the line,
// the point is added once and the start vertex closes the piece instead.
// The intersection is computed by a serial multiply-divide unit that runs
// while the start vertex is emitted. One vertex is processed at a time:
// in_stall_o is high from acceptance until its last result is in the output
// register. A stalled receiver holds the output register and the sequencer
// waits. Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i
// while idle; cfg_ready_o is always high and unknown indexes are ignored.
// Reset clears the cut registers, drops any held vertex and empties the
// output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module polyline_split_at_axis_line #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      vertex_x_i,
  input  logic signed [COORD_BITS-1:0]      vertex_y_i,
  input  logic                              path_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      point_x_o,
  output logic signed [COORD_BITS-1:0]      point_y_o,
  output logic                              piece_end_o,
  output logic                              path_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psal_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i
);

  localparam int unsigned W = COORD_BITS;

  psal_pkg::state_e state_q, state_d;

  logic                cut_axis_q;
  logic signed [W-1:0] cut_coord_q;

  // The held vertex always holds the newest accepted vertex; prev holds the
  // vertex before it while its segment is being worked on.
  logic signed [W-1:0] held_x_q, held_y_q, prev_x_q, prev_y_q;
  logic                held_valid_q;
  logic                last_q, cross_q, eq_q, neg_q;
  logic signed [W-1:0] ho_q;

  logic                out_valid_q, pe_q, pend_q;
  logic signed [W-1:0] px_q, py_q;

  logic                accept;
  logic                slot_free;
  logic                emit;
  logic signed [W-1:0] ha, ho, va, vo;
  logic signed [W:0]   n1, n2, dd;
  logic [W:0]          n1_mag, n2_mag, d_mag;
  logic                crossing;
  logic                md_start, md_done;
  logic [W:0]          md_quot;
  logic signed [W:0]   io_full;
  logic signed [W-1:0] ix, iy;
  logic signed [W-1:0] ex, ey;
  logic                epe, epend;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != psal_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_axis_q  <= 1'b0;
      cut_coord_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        psal_pkg::CFG_CUT_AXIS:  cut_axis_q  <= cfg_data_i[0];
        psal_pkg::CFG_CUT_COORD: cut_coord_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Segment from the held vertex to the new one, seen along the cut axis (a)
  // and along the other axis (o).
  assign ha = cut_axis_q ? held_y_q : held_x_q;
  assign ho = cut_axis_q ? held_x_q : held_y_q;
  assign va = cut_axis_q ? vertex_y_i : vertex_x_i;
  assign vo = cut_axis_q ? vertex_x_i : vertex_y_i;

  assign n1 = {cut_coord_q[W-1], cut_coord_q} - {ha[W-1], ha};
  assign n2 = {vo[W-1], vo} - {ho[W-1], ho};
  assign dd = {va[W-1], va} - {ha[W-1], ha};

  assign n1_mag = n1[W] ? -n1 : n1;
  assign n2_mag = n2[W] ? -n2 : n2;
  assign d_mag  = dd[W] ? -dd : dd;

  assign crossing = ((ha <= cut_coord_q) && (va > cut_coord_q)) ||
                    ((ha >= cut_coord_q) && (va < cut_coord_q));

  assign md_start = accept && held_valid_q && crossing;

  psal_muldiv #(
    .W (W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (n1_mag),
    .b_i     (n2_mag),
    .d_i     (d_mag),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q     <= '0;
      held_y_q     <= '0;
      held_valid_q <= 1'b0;
    end else if (accept) begin
      held_x_q     <= vertex_x_i;
      held_y_q     <= vertex_y_i;
      held_valid_q <= !path_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_x_q <= held_x_q;
      prev_y_q <= held_y_q;
      last_q   <= path_last_i;
      cross_q  <= crossing;
      // The intersection equals the start vertex exactly when it sits on the line.
      eq_q     <= (ha == cut_coord_q);
      neg_q    <= n1[W] ^ n2[W] ^ dd[W];
      ho_q     <= ho;
    end
  end

  // The quotient never exceeds the span on the other axis, so the sum fits.
  assign io_full = {ho_q[W-1], ho_q} + (neg_q ? -$signed(md_quot) : $signed(md_quot));
  assign ix      = cut_axis_q ? io_full[W-1:0] : cut_coord_q;
  assign iy      = cut_axis_q ? cut_coord_q : io_full[W-1:0];

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    ex      = held_x_q;
    ey      = held_y_q;
    epe     = 1'b0;
    epend   = 1'b0;
    case (state_q)
      psal_pkg::S_IDLE: begin
        if (accept) begin
          if (held_valid_q) begin
            state_d = psal_pkg::S_EMIT_H;
          end else if (path_last_i) begin
            state_d = psal_pkg::S_EMIT_V;
          end
        end
      end
      psal_pkg::S_EMIT_H: begin
        ex  = prev_x_q;
        ey  = prev_y_q;
        epe = cross_q && eq_q;
        if (slot_free) begin
          emit = 1'b1;
          if (cross_q) begin
            state_d = psal_pkg::S_CALC;
          end else if (last_q) begin
            state_d = psal_pkg::S_EMIT_V;
          end else begin
            state_d = psal_pkg::S_IDLE;
          end
        end
      end
      psal_pkg::S_CALC: begin
        if (md_done) begin
          state_d = eq_q ? psal_pkg::S_EMIT_I0 : psal_pkg::S_EMIT_I1;
        end
      end
      psal_pkg::S_EMIT_I1: begin
        ex  = ix;
        ey  = iy;
        epe = 1'b1;
        if (slot_free) begin
          emit    = 1'b1;
          state_d = psal_pkg::S_EMIT_I0;
        end
      end
      psal_pkg::S_EMIT_I0: begin
        ex = ix;
        ey = iy;
        if (slot_free) begin
          emit    = 1'b1;
          state_d = last_q ? psal_pkg::S_EMIT_V : psal_pkg::S_IDLE;
        end
      end
      psal_pkg::S_EMIT_V: begin
        epe   = 1'b1;
        epend = 1'b1;
        if (slot_free) begin
          emit    = 1'b1;
          state_d = psal_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psal_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psal_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q   <= ex;
      py_q   <= ey;
      pe_q   <= epe;
      pend_q <= epend;
    end
  end

  assign out_valid_o = out_valid_q;
  assign point_x_o   = px_q;
  assign point_y_o   = py_q;
  assign piece_end_o = pe_q;
  assign path_end_o  = pend_q;

  `ASSERT_IMPL(a_quot_ready,
    (state_q == psal_pkg::S_EMIT_I1 || state_q == psal_pkg::S_EMIT_I0) |-> md_done)
  `ASSERT_IMPL(a_path_end_closes_piece, out_valid_o && path_end_o |-> piece_end_o)
  `ASSERT_IMPL(a_state_onehot, $onehot(state_q))

endmodule
